[rtl/sfs_pkg.sv]
// shared types, register codes and reset values of the select fire sequencer
`timescale 1ns / 1ps

package sfs_pkg;

  localparam int unsigned DebW    = 10;
  localparam int unsigned SpinW   = 16;
  localparam int unsigned GapW    = 12;
  localparam int unsigned FeedW   = 12;
  localparam int unsigned PulseW  = 8;
  localparam int unsigned BurstW  = 4;
  localparam int unsigned RoundW  = 8;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 16;
  localparam int unsigned InDatW  = 8;
  localparam int unsigned OutDatW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DEBOUNCE = 3'd0,
    CFG_SPINUP   = 3'd1,
    CFG_GAP      = 3'd2,
    CFG_FEED     = 3'd3,
    CFG_PULSE    = 3'd4,
    CFG_BURST    = 3'd5,
    CFG_MAGAZINE = 3'd6
  } cfg_sel_e;

  localparam logic [1:0] MODE_SAFE  = 2'd0;
  localparam logic [1:0] MODE_SEMI  = 2'd1;
  localparam logic [1:0] MODE_BURST = 2'd2;
  localparam logic [1:0] MODE_AUTO  = 2'd3;

  localparam logic [DebW-1:0]   DebounceRst = 10'd200;
  localparam logic [SpinW-1:0]  SpinupRst   = 16'd1000;
  localparam logic [GapW-1:0]   GapRst      = 12'd250;
  localparam logic [FeedW-1:0]  FeedRst     = 12'd250;
  localparam logic [PulseW-1:0] PulseRst    = 8'd50;
  localparam logic [BurstW-1:0] BurstRst    = 4'd3;
  localparam logic [RoundW-1:0] MagazineRst = 8'd60;

  typedef struct packed {
    logic [DebW-1:0]   debounce_ticks;
    logic [SpinW-1:0]  spinup_ticks;
    logic [GapW-1:0]   pusher_gap_ticks;
    logic [FeedW-1:0]  feed_ticks;
    logic [PulseW-1:0] pulse_ticks;
    logic [BurstW-1:0] burst_length;
    logic [RoundW-1:0] magazine_capacity;
  } cfg_t;

  // raw switch levels, active low
  typedef struct packed {
    logic rev_level;
    logic trigger_level;
    logic mode_button_level;
  } levels_t;

  typedef struct packed {
    logic rev;
    logic trig;
    logic mode;
  } due_t;

  // packed lowest field last so that flywheel_run lands in bit 0
  typedef struct packed {
    logic              sequence_busy;
    logic [RoundW-1:0] rounds_left;
    logic [1:0]        fire_mode;
    logic              feed_drive;
    logic              pusher_drive;
    logic              flywheel_run;
  } result_t;

endpackage

[rtl/sfs_sampler.sv]
// per switch debounce timers that decide when each level is sampled
`timescale 1ns / 1ps

module sfs_sampler (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    accept_i,
  input  logic                    frozen_i,
  input  logic [sfs_pkg::DebW-1:0] debounce_ticks_i,
  output sfs_pkg::due_t           due_o
);

  logic [sfs_pkg::DebW-1:0] mode_tmr_q, mode_tmr_d;
  logic [sfs_pkg::DebW-1:0] trig_tmr_q, trig_tmr_d;
  logic [sfs_pkg::DebW-1:0] rev_tmr_q, rev_tmr_d;

  function automatic logic [sfs_pkg::DebW-1:0] next_tmr(
    input logic [sfs_pkg::DebW-1:0] tmr,
    input logic [sfs_pkg::DebW-1:0] lim,
    input logic                     frozen
  );
    logic [sfs_pkg::DebW-1:0] r;
    if (tmr >= lim) begin
      r = frozen ? tmr : '0;
    end else begin
      r = tmr + 1'b1;
    end
    return r;
  endfunction

  always_comb begin
    due_o.mode = !frozen_i && (mode_tmr_q >= debounce_ticks_i);
    due_o.trig = !frozen_i && (trig_tmr_q >= debounce_ticks_i);
    due_o.rev  = !frozen_i && (rev_tmr_q >= debounce_ticks_i);
    mode_tmr_d = next_tmr(mode_tmr_q, debounce_ticks_i, frozen_i);
    trig_tmr_d = next_tmr(trig_tmr_q, debounce_ticks_i, frozen_i);
    rev_tmr_d  = next_tmr(rev_tmr_q, debounce_ticks_i, frozen_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_tmr_q <= '0;
      trig_tmr_q <= '0;
      rev_tmr_q  <= '0;
    end else if (accept_i) begin
      mode_tmr_q <= mode_tmr_d;
      trig_tmr_q <= trig_tmr_d;
      rev_tmr_q  <= rev_tmr_d;
    end
  end

  a_rev_sample_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && due_o.rev) |=> (rev_tmr_q == '0))
    else $error("rev timer not cleared after sample");

endmodule

[rtl/sfs_core.sv]
// fire mode, spin-up, shot counting and shot phase sequencing
`timescale 1ns / 1ps

module sfs_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       accept_i,
  input  sfs_pkg::levels_t           levels_i,
  input  sfs_pkg::due_t              due_i,
  input  sfs_pkg::cfg_t              cfg_i,
  input  logic                       reload_i,
  input  logic [sfs_pkg::RoundW-1:0] reload_value_i,
  output logic                       frozen_o,
  output sfs_pkg::result_t           result_o
);

  typedef enum logic [4:0] {
    PH_IDLE  = 5'b00001,
    PH_PULSE = 5'b00010,
    PH_GAP   = 5'b00100,
    PH_WAIT  = 5'b01000,
    PH_FEED  = 5'b10000
  } phase_e;

  typedef struct packed {
    phase_e      phase;
    logic [12:0] left;
    logic        set_feed;
  } enter_t;

  function automatic phase_e next_phase(input phase_e p);
    phase_e r;
    unique case (p)
      PH_PULSE: r = PH_GAP;
      PH_GAP:   r = PH_WAIT;
      PH_WAIT:  r = PH_FEED;
      default:  r = PH_IDLE;
    endcase
    return r;
  endfunction

  // enter phase p, skipping zero length phases
  function automatic enter_t enter_phase(input phase_e p, input sfs_pkg::cfg_t c);
    enter_t r;
    logic   pulse_ok, gap_ok, wait_ok, feed_ok;
    pulse_ok   = (p == PH_PULSE);
    gap_ok     = pulse_ok || (p == PH_GAP);
    wait_ok    = gap_ok || (p == PH_WAIT);
    feed_ok    = wait_ok || (p == PH_FEED);
    r.phase    = PH_IDLE;
    r.left     = '0;
    r.set_feed = 1'b0;
    if (pulse_ok && c.pulse_ticks != '0) begin
      r.phase = PH_PULSE;
      r.left  = {5'd0, c.pulse_ticks};
    end else if (gap_ok && c.pusher_gap_ticks != '0) begin
      r.phase = PH_GAP;
      r.left  = {1'b0, c.pusher_gap_ticks};
    end else if (wait_ok && c.feed_ticks != '0) begin
      r.phase = PH_WAIT;
      r.left  = {1'b0, c.feed_ticks};
    end else if (feed_ok) begin
      r.set_feed = 1'b1;
      if (c.feed_ticks != '0) begin
        r.phase = PH_FEED;
        r.left  = {c.feed_ticks, 1'b0};
      end
    end
    return r;
  endfunction

  logic [1:0]                   mode_q, mode_d;
  logic                         locked_q, locked_d;
  logic                         trig_held_q, trig_held_d;
  logic                         rev_held_q, rev_held_d;
  logic [sfs_pkg::SpinW-1:0]    spin_q, spin_d;
  logic                         armed_q, armed_d;
  logic [sfs_pkg::BurstW-1:0]   pending_q, pending_d;
  logic                         shots_valid_q, shots_valid_d;
  logic [sfs_pkg::RoundW-1:0]   round_q, round_d;
  phase_e                       phase_q, phase_d, ph1;
  logic [12:0]                  left_q, left_d, left1, left2;
  logic [12:0]                  pcool_q, pcool_d, pcool1;
  logic [13:0]                  fcool_q, fcool_d, fcool1;
  logic                         fire;
  enter_t                       e1, e2;

  assign frozen_o = (phase_q != PH_IDLE);

  always_comb begin
    mode_d        = mode_q;
    locked_d      = locked_q;
    trig_held_d   = trig_held_q;
    rev_held_d    = rev_held_q;
    armed_d       = armed_q;
    pending_d     = pending_q;
    shots_valid_d = shots_valid_q;
    round_d       = round_q;
    fire          = 1'b0;
    spin_d        = (spin_q != '0) ? spin_q - 1'b1 : spin_q;

    if (phase_q == PH_IDLE) begin
      if (due_i.rev) begin
        if (levels_i.rev_level) begin
          rev_held_d = 1'b0;
          armed_d    = 1'b0;
        end else begin
          rev_held_d = 1'b1;
        end
      end
      if (due_i.trig) begin
        if (levels_i.trigger_level) begin
          trig_held_d   = 1'b0;
          shots_valid_d = 1'b0;
        end else begin
          trig_held_d = 1'b1;
        end
      end
      if (due_i.mode) begin
        if (levels_i.mode_button_level) begin
          locked_d = 1'b0;
        end else if (!locked_q) begin
          mode_d   = mode_q + 2'd1;
          locked_d = 1'b1;
        end
      end
      if (mode_d != sfs_pkg::MODE_SAFE) begin
        if (rev_held_d && !armed_d) begin
          armed_d = 1'b1;
          spin_d  = cfg_i.spinup_ticks;
        end
        if (trig_held_d && rev_held_d) begin
          case (mode_d)
            sfs_pkg::MODE_SEMI: begin
              if (!shots_valid_d) begin
                pending_d     = sfs_pkg::BurstW'(1);
                shots_valid_d = 1'b1;
              end
            end
            sfs_pkg::MODE_BURST: begin
              if (!shots_valid_d) begin
                pending_d     = cfg_i.burst_length;
                shots_valid_d = 1'b1;
              end
            end
            default: begin
              pending_d     = sfs_pkg::BurstW'(1);
              shots_valid_d = 1'b1;
            end
          endcase
          fire = armed_d && (spin_d == '0) && (fcool_q == '0) && (pcool_q == '0) &&
                 shots_valid_d && (pending_d != '0);
        end
      end
    end

    e1 = enter_phase(PH_PULSE, cfg_i);
    if (fire) begin
      pending_d = pending_d - 1'b1;
      if (round_q != '0) begin
        round_d = round_q - 1'b1;
      end
    end

    ph1    = fire ? e1.phase : phase_q;
    left1  = fire ? e1.left : left_q;
    pcool1 = fire ? {cfg_i.pusher_gap_ticks, 1'b0} : pcool_q;
    fcool1 = (fire && e1.set_feed) ? {cfg_i.feed_ticks, 2'b00} : fcool_q;

    result_o.flywheel_run  = rev_held_d;
    result_o.pusher_drive  = (ph1 == PH_PULSE);
    result_o.feed_drive    = (ph1 == PH_FEED);
    result_o.fire_mode     = mode_d;
    result_o.rounds_left   = round_d;
    result_o.sequence_busy = fire || (phase_q != PH_IDLE);

    pcool_d = (pcool1 != '0) ? pcool1 - 1'b1 : pcool1;
    fcool_d = (fcool1 != '0) ? fcool1 - 1'b1 : fcool1;
    phase_d = ph1;
    left_d  = left1;
    left2   = (left1 != '0) ? left1 - 1'b1 : left1;
    e2      = enter_phase(next_phase(ph1), cfg_i);
    if (ph1 != PH_IDLE) begin
      left_d = left2;
      if (left2 == '0) begin
        phase_d = e2.phase;
        left_d  = e2.left;
        if (e2.set_feed) begin
          fcool_d = {cfg_i.feed_ticks, 2'b00};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        <= sfs_pkg::MODE_SAFE;
      locked_q      <= 1'b0;
      trig_held_q   <= 1'b1;
      rev_held_q    <= 1'b1;
      spin_q        <= '0;
      armed_q       <= 1'b0;
      pending_q     <= '0;
      shots_valid_q <= 1'b0;
      round_q       <= sfs_pkg::MagazineRst;
      phase_q       <= PH_IDLE;
      left_q        <= '0;
      pcool_q       <= '0;
      fcool_q       <= '0;
    end else begin
      if (accept_i) begin
        mode_q        <= mode_d;
        locked_q      <= locked_d;
        trig_held_q   <= trig_held_d;
        rev_held_q    <= rev_held_d;
        spin_q        <= spin_d;
        armed_q       <= armed_d;
        pending_q     <= pending_d;
        shots_valid_q <= shots_valid_d;
        phase_q       <= phase_d;
        left_q        <= left_d;
        pcool_q       <= pcool_d;
        fcool_q       <= fcool_d;
      end
      if (reload_i) begin
        round_q <= reload_value_i;
      end else if (accept_i) begin
        round_q <= round_d;
      end
    end
  end

  a_phase_has_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != PH_IDLE) |-> (left_q != '0))
    else $error("active shot phase with zero length left");

  a_mode_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && frozen_o) |=> $stable(mode_q))
    else $error("fire mode changed during a shot sequence");

endmodule

[rtl/sfs_out_buf.sv]
// two entry result buffer between the core and the output stream
`timescale 1ns / 1ps

module sfs_out_buf (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  sfs_pkg::result_t data_i,
  output logic             ready_o,
  output logic             valid_o,
  output sfs_pkg::result_t data_o,
  input  logic             pop_ready_i
);

  logic             valid0_q, valid0_d, valid1_q, valid1_d;
  sfs_pkg::result_t data0_q, data0_d, data1_q, data1_d;
  logic             pop;

  assign ready_o = !valid1_q;
  assign valid_o = valid0_q;
  assign data_o  = data0_q;
  assign pop     = valid0_q && pop_ready_i;

  always_comb begin
    valid0_d = valid0_q;
    valid1_d = valid1_q;
    data0_d  = data0_q;
    data1_d  = data1_q;
    if (pop) begin
      if (valid1_q) begin
        data0_d  = data1_q;
        valid1_d = 1'b0;
      end else if (push_i) begin
        data0_d = data_i;
      end else begin
        valid0_d = 1'b0;
      end
    end else if (push_i) begin
      if (!valid0_q) begin
        data0_d  = data_i;
        valid0_d = 1'b1;
      end else begin
        data1_d  = data_i;
        valid1_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid0_q <= 1'b0;
      valid1_q <= 1'b0;
    end else begin
      valid0_q <= valid0_d;
      valid1_q <= valid1_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data0_q <= data0_d;
    data1_q <= data1_d;
  end

  a_skid_behind_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid1_q |-> valid0_q)
    else $error("skid entry held without head entry");

endmodule

[rtl/select_fire_sequencer_top.sv]
// top level: config registers, switch sampler, fire core and result buffer
// a result beat is registered in the result buffer before it is offered on m_axis
// throughput: one input beat per cycle while the result buffer has room
// a two entry result buffer keeps s_axis ready while one result waits
// reset: config returns to its defaults, rounds to 60, mode safe, no sequence
`timescale 1ns / 1ps

module select_fire_sequencer_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  // mode_button_level, trigger_level, rev_level
  input  logic [sfs_pkg::InDatW-1:0]  s_axis_tdata_i,
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  // flywheel_run, pusher_drive, feed_drive, fire_mode, rounds_left, sequence_busy
  output logic [sfs_pkg::OutDatW-1:0] m_axis_tdata_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [sfs_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [sfs_pkg::CfgDatW-1:0] cfg_data_i
);

  sfs_pkg::cfg_t    cfg_q;
  sfs_pkg::levels_t levels;
  sfs_pkg::due_t    due;
  sfs_pkg::result_t core_res, out_res;
  logic             accept, frozen, reload, cfg_wr;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;
  assign accept      = s_axis_tvalid_i && s_axis_tready_o;
  assign reload      = cfg_wr && (sfs_pkg::cfg_sel_e'(cfg_index_i) == sfs_pkg::CFG_MAGAZINE);

  assign levels.mode_button_level = s_axis_tdata_i[0];
  assign levels.trigger_level     = s_axis_tdata_i[1];
  assign levels.rev_level         = s_axis_tdata_i[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ticks    <= sfs_pkg::DebounceRst;
      cfg_q.spinup_ticks      <= sfs_pkg::SpinupRst;
      cfg_q.pusher_gap_ticks  <= sfs_pkg::GapRst;
      cfg_q.feed_ticks        <= sfs_pkg::FeedRst;
      cfg_q.pulse_ticks       <= sfs_pkg::PulseRst;
      cfg_q.burst_length      <= sfs_pkg::BurstRst;
      cfg_q.magazine_capacity <= sfs_pkg::MagazineRst;
    end else if (cfg_wr) begin
      unique case (sfs_pkg::cfg_sel_e'(cfg_index_i))
        sfs_pkg::CFG_DEBOUNCE: cfg_q.debounce_ticks   <= cfg_data_i[sfs_pkg::DebW-1:0];
        sfs_pkg::CFG_SPINUP:   cfg_q.spinup_ticks     <= cfg_data_i[sfs_pkg::SpinW-1:0];
        sfs_pkg::CFG_GAP:      cfg_q.pusher_gap_ticks <= cfg_data_i[sfs_pkg::GapW-1:0];
        sfs_pkg::CFG_FEED:     cfg_q.feed_ticks       <= cfg_data_i[sfs_pkg::FeedW-1:0];
        sfs_pkg::CFG_PULSE:    cfg_q.pulse_ticks      <= cfg_data_i[sfs_pkg::PulseW-1:0];
        sfs_pkg::CFG_BURST:    cfg_q.burst_length     <= cfg_data_i[sfs_pkg::BurstW-1:0];
        sfs_pkg::CFG_MAGAZINE: cfg_q.magazine_capacity <= cfg_data_i[sfs_pkg::RoundW-1:0];
        default: ;
      endcase
    end
  end

  sfs_sampler u_sampler (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .accept_i         (accept),
    .frozen_i         (frozen),
    .debounce_ticks_i (cfg_q.debounce_ticks),
    .due_o            (due)
  );

  sfs_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .levels_i       (levels),
    .due_i          (due),
    .cfg_i          (cfg_q),
    .reload_i       (reload),
    .reload_value_i (cfg_data_i[sfs_pkg::RoundW-1:0]),
    .frozen_o       (frozen),
    .result_o       (core_res)
  );

  sfs_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .data_i      (core_res),
    .ready_o     (s_axis_tready_o),
    .valid_o     (m_axis_tvalid_o),
    .data_o      (out_res),
    .pop_ready_i (m_axis_tready_i)
  );

  assign m_axis_tdata_o = {2'b00, out_res};

endmodule

[sim/tb_top.sv]
// self-checking testbench for the select fire sequencer top level
`timescale 1ns / 1ps

module tb_top;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_PULSE = 3'd1,
    PH_GAP   = 3'd2,
    PH_WAIT  = 3'd3,
    PH_FEED  = 3'd4
  } shot_phase_e;

  typedef struct {
    bit                          is_reg;
    logic [sfs_pkg::CfgIdxW-1:0] reg_idx;
    logic [sfs_pkg::CfgDatW-1:0] reg_data;
    sfs_pkg::levels_t            lv;
    bit                          fixed;
    sfs_pkg::result_t            want;
  } plan_row_t;

  localparam logic [sfs_pkg::CfgIdxW-1:0] CFG_UNUSED = 3'd7;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned RAND_ITEMS  = 350;

  // raw levels, a 0 bit means pressed: {rev, trigger, mode}
  localparam sfs_pkg::levels_t LV_RELEASED = 3'b111;
  localparam sfs_pkg::levels_t LV_MODE     = 3'b110;
  localparam sfs_pkg::levels_t LV_REV      = 3'b011;
  localparam sfs_pkg::levels_t LV_REV_MODE = 3'b010;
  localparam sfs_pkg::levels_t LV_SHOOT    = 3'b001;
  localparam sfs_pkg::levels_t LV_ALL      = 3'b000;

  localparam sfs_pkg::result_t RESET_OUT = '{sequence_busy: 1'b0,
                                             rounds_left: sfs_pkg::MagazineRst,
                                             fire_mode: sfs_pkg::MODE_SAFE,
                                             feed_drive: 1'b0, pusher_drive: 1'b0,
                                             flywheel_run: 1'b1};

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        s_valid = 1'b0;
  logic                        s_ready;
  logic [sfs_pkg::InDatW-1:0]  s_data = '0;
  logic                        m_valid;
  logic                        m_ready = 1'b0;
  logic [sfs_pkg::OutDatW-1:0] m_data;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [sfs_pkg::CfgIdxW-1:0] cfg_index = '0;
  logic [sfs_pkg::CfgDatW-1:0] cfg_data = '0;

  // typed expectation that travels with a directed beat
  logic             fixed_q = 1'b0;
  sfs_pkg::result_t want_q = '0;

  int unsigned src_idle = 0;
  int unsigned dst_idle = 0;
  int unsigned mismatches = 0;
  int unsigned stall_cycles = 0;

  // predicted block state
  sfs_pkg::cfg_t              cfg;
  logic [1:0]                 mode_now;
  logic                       mode_locked, trig_held, rev_held;
  logic [sfs_pkg::DebW-1:0]   smp_timer [3];
  logic [sfs_pkg::SpinW-1:0]  spin_left;
  logic                       spin_armed;
  logic [4:0]                 shots_left;
  logic                       pull_active;
  logic [sfs_pkg::RoundW-1:0] rounds;
  shot_phase_e                shot_phase;
  logic [12:0]                phase_left;
  logic [12:0]                push_cool;
  logic [13:0]                feed_cool;
  int unsigned                shots_fired;

  sfs_pkg::result_t outputs_due [$];
  plan_row_t        plan [$];
  sfs_pkg::levels_t held_lv = LV_RELEASED;

  select_fire_sequencer_top i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic void reset_state();
    cfg.debounce_ticks    = sfs_pkg::DebounceRst;
    cfg.spinup_ticks      = sfs_pkg::SpinupRst;
    cfg.pusher_gap_ticks  = sfs_pkg::GapRst;
    cfg.feed_ticks        = sfs_pkg::FeedRst;
    cfg.pulse_ticks       = sfs_pkg::PulseRst;
    cfg.burst_length      = sfs_pkg::BurstRst;
    cfg.magazine_capacity = sfs_pkg::MagazineRst;
    mode_now = sfs_pkg::MODE_SAFE; mode_locked = 1'b0; trig_held = 1'b1; rev_held = 1'b1;
    foreach (smp_timer[i]) smp_timer[i] = '0;
    spin_left = '0; spin_armed = 1'b0;
    shots_left = '0; pull_active = 1'b0;
    rounds = sfs_pkg::MagazineRst;
    shot_phase = PH_IDLE; phase_left = '0; push_cool = '0; feed_cool = '0;
    shots_fired = 0;
  endfunction

  function automatic void write_model_reg(logic [sfs_pkg::CfgIdxW-1:0] idx,
                                          logic [sfs_pkg::CfgDatW-1:0] d);
    case (idx)
      sfs_pkg::CFG_DEBOUNCE: cfg.debounce_ticks = d[sfs_pkg::DebW-1:0];
      sfs_pkg::CFG_SPINUP:   cfg.spinup_ticks = d[sfs_pkg::SpinW-1:0];
      sfs_pkg::CFG_GAP:      cfg.pusher_gap_ticks = d[sfs_pkg::GapW-1:0];
      sfs_pkg::CFG_FEED:     cfg.feed_ticks = d[sfs_pkg::FeedW-1:0];
      sfs_pkg::CFG_PULSE:    cfg.pulse_ticks = d[sfs_pkg::PulseW-1:0];
      sfs_pkg::CFG_BURST:    cfg.burst_length = d[sfs_pkg::BurstW-1:0];
      sfs_pkg::CFG_MAGAZINE: begin
        cfg.magazine_capacity = d[sfs_pkg::RoundW-1:0];
        rounds = d[sfs_pkg::RoundW-1:0];
      end
      default: ;
    endcase
  endfunction

  function automatic logic [12:0] phase_len(shot_phase_e p);
    case (p)
      PH_PULSE: return 13'(cfg.pulse_ticks);
      PH_GAP:   return 13'(cfg.pusher_gap_ticks);
      PH_WAIT:  return 13'(cfg.feed_ticks);
      default:  return {cfg.feed_ticks, 1'b0};
    endcase
  endfunction

  // zero length phases are skipped, past the feed phase the shot is over
  function automatic void enter_phase(int unsigned first);
    int unsigned p;
    logic [12:0] len;
    p = first;
    while (p <= PH_FEED) begin
      len = phase_len(shot_phase_e'(p));
      if (p == PH_FEED) feed_cool = {cfg.feed_ticks, 2'b00};
      if (len != 0) begin
        shot_phase = shot_phase_e'(p);
        phase_left = len;
        return;
      end
      p++;
    end
    shot_phase = PH_IDLE;
    phase_left = '0;
  endfunction

  function automatic bit sample_due(int unsigned i);
    if (smp_timer[i] >= cfg.debounce_ticks) begin
      smp_timer[i] = '0;
      return 1'b1;
    end
    smp_timer[i]++;
    return 1'b0;
  endfunction

  function automatic sfs_pkg::result_t fire_tick(sfs_pkg::levels_t lv);
    sfs_pkg::result_t r;
    bit fired;
    fired = 1'b0;
    if (spin_left != 0) spin_left--;
    if (shot_phase != PH_IDLE) begin
      foreach (smp_timer[i])
        if (smp_timer[i] < cfg.debounce_ticks) smp_timer[i]++;
    end else begin
      if (sample_due(2)) begin
        if (lv.rev_level) begin
          rev_held = 1'b0;
          spin_armed = 1'b0;
        end else begin
          rev_held = 1'b1;
        end
      end
      if (sample_due(1)) begin
        if (lv.trigger_level) begin
          trig_held = 1'b0;
          pull_active = 1'b0;
        end else begin
          trig_held = 1'b1;
        end
      end
      if (sample_due(0)) begin
        if (lv.mode_button_level) begin
          mode_locked = 1'b0;
        end else if (!mode_locked) begin
          mode_now = mode_now + 2'd1;
          mode_locked = 1'b1;
        end
      end
      if (mode_now != sfs_pkg::MODE_SAFE) begin
        if (rev_held && !spin_armed) begin
          spin_armed = 1'b1;
          spin_left = cfg.spinup_ticks;
        end
        if (trig_held && rev_held) begin
          case (mode_now)
            sfs_pkg::MODE_SEMI: if (!pull_active) begin
              shots_left = 5'd1;
              pull_active = 1'b1;
            end
            sfs_pkg::MODE_BURST: if (!pull_active) begin
              shots_left = {1'b0, cfg.burst_length};
              pull_active = 1'b1;
            end
            default: begin
              shots_left = 5'd1;
              pull_active = 1'b1;
            end
          endcase
          if (spin_armed && spin_left == 0 && feed_cool == 0 && push_cool == 0 &&
              pull_active && shots_left != 0) begin
            shots_left--;
            if (rounds != 0) rounds--;
            push_cool = {cfg.pusher_gap_ticks, 1'b0};
            enter_phase(PH_PULSE);
            fired = 1'b1;
            shots_fired++;
          end
        end
      end
    end
    r.sequence_busy = fired || (shot_phase != PH_IDLE);
    r.pusher_drive  = (shot_phase == PH_PULSE);
    r.feed_drive    = (shot_phase == PH_FEED);
    if (push_cool != 0) push_cool--;
    if (feed_cool != 0) feed_cool--;
    if (shot_phase != PH_IDLE) begin
      if (phase_left != 0) phase_left--;
      if (phase_left == 0) enter_phase(int'(shot_phase) + 1);
    end
    r.flywheel_run = rev_held;
    r.fire_mode    = mode_now;
    r.rounds_left  = rounds;
    return r;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s expected %0d got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    sfs_pkg::result_t got, want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) write_model_reg(cfg_index, cfg_data);
      if (s_valid && s_ready) begin
        want = fire_tick(sfs_pkg::levels_t'(s_data[2:0]));
        if (fixed_q) want = want_q;
        outputs_due.push_back(want);
      end
      if (m_valid && m_ready) begin
        got = sfs_pkg::result_t'(m_data[$bits(sfs_pkg::result_t)-1:0]);
        if (outputs_due.size() == 0) begin
          $error("output beat 0x%0h with nothing expected", m_data);
          mismatches++;
        end else begin
          want = outputs_due.pop_front();
          check_field("flywheel_run", want.flywheel_run, got.flywheel_run);
          check_field("pusher_drive", want.pusher_drive, got.pusher_drive);
          check_field("feed_drive", want.feed_drive, got.feed_drive);
          check_field("fire_mode", want.fire_mode, got.fire_mode);
          check_field("rounds_left", want.rounds_left, got.rounds_left);
          check_field("sequence_busy", want.sequence_busy, got.sequence_busy);
        end
      end
    end
  end

  always @(posedge clk) begin
    m_ready <= ($urandom_range(0, 99) >= dst_idle);
  end

  always @(posedge clk) begin
    if (!rst_n || (s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("select_fire_sequencer_top verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // switches hold their level for a while, with an occasional one-tick glitch
  function automatic sfs_pkg::levels_t next_levels();
    sfs_pkg::levels_t lv;
    if ($urandom_range(0, 15) == 0) held_lv.mode_button_level ^= 1'b1;
    if ($urandom_range(0, 7) == 0)  held_lv.trigger_level ^= 1'b1;
    if ($urandom_range(0, 29) == 0) held_lv.rev_level ^= 1'b1;
    lv = held_lv;
    if ($urandom_range(0, 39) == 0) lv[$urandom_range(0, 2)] ^= 1'b1;
    return lv;
  endfunction

  function automatic void add_reg(logic [sfs_pkg::CfgIdxW-1:0] idx,
                                  logic [sfs_pkg::CfgDatW-1:0] d);
    plan.push_back('{is_reg: 1'b1, reg_idx: idx, reg_data: d, lv: LV_RELEASED,
                     fixed: 1'b0, want: '0});
  endfunction

  function automatic void add_tick(sfs_pkg::levels_t lv);
    plan.push_back('{is_reg: 1'b0, reg_idx: '0, reg_data: '0, lv: lv,
                     fixed: 1'b0, want: '0});
  endfunction

  function automatic void add_fixed(sfs_pkg::levels_t lv, sfs_pkg::result_t want);
    plan.push_back('{is_reg: 1'b0, reg_idx: '0, reg_data: '0, lv: lv,
                     fixed: 1'b1, want: want});
  endfunction

  task automatic send_tick(sfs_pkg::levels_t lv, bit fixed, sfs_pkg::result_t want);
    while ($urandom_range(0, 99) < src_idle) begin
      s_valid <= 1'b0;
      @(posedge clk);
    end
    s_valid <= 1'b1;
    s_data  <= {{(sfs_pkg::InDatW-3){1'b0}}, lv};
    fixed_q <= fixed;
    want_q  <= want;
    do @(posedge clk); while (!s_ready);
  endtask

  task automatic drain();
    s_valid <= 1'b0;
    do @(negedge clk); while (outputs_due.size() != 0);
    @(posedge clk);
  endtask

  // bits above the register width are filled with noise
  task automatic write_reg(logic [sfs_pkg::CfgIdxW-1:0] idx, int unsigned val,
                           int unsigned w);
    logic [sfs_pkg::CfgDatW-1:0] word;
    word = sfs_pkg::CfgDatW'(($urandom << w) | val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= word;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic program_regs(int unsigned deb, int unsigned spin, int unsigned gap,
                              int unsigned feed, int unsigned pulse, int unsigned burst,
                              int unsigned mag);
    drain();
    write_reg(sfs_pkg::CFG_DEBOUNCE, deb, sfs_pkg::DebW);
    write_reg(sfs_pkg::CFG_SPINUP, spin, sfs_pkg::SpinW);
    write_reg(sfs_pkg::CFG_GAP, gap, sfs_pkg::GapW);
    write_reg(sfs_pkg::CFG_FEED, feed, sfs_pkg::FeedW);
    write_reg(sfs_pkg::CFG_PULSE, pulse, sfs_pkg::PulseW);
    write_reg(sfs_pkg::CFG_BURST, burst, sfs_pkg::BurstW);
    write_reg(sfs_pkg::CFG_MAGAZINE, mag, sfs_pkg::RoundW);
    write_reg(CFG_UNUSED, $urandom, 0);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    bit cfg_open;
    int unsigned first_shot;
    int unsigned guard;
    reset_state();
    cfg_open = 1'b0;
    src_idle = 24;
    dst_idle = 87;

    // after reset nothing is sampled until the debounce time has passed
    add_fixed(LV_RELEASED, RESET_OUT);
    add_fixed(LV_ALL, RESET_OUT);
    add_fixed(LV_RELEASED, RESET_OUT);
    // all timing at zero, upper data bits must be ignored
    add_reg(sfs_pkg::CFG_DEBOUNCE, 16'hFC00);
    add_reg(sfs_pkg::CFG_SPINUP, 16'h0000);
    add_reg(sfs_pkg::CFG_GAP, 16'hF000);
    add_reg(sfs_pkg::CFG_FEED, 16'h0000);
    add_reg(sfs_pkg::CFG_PULSE, 16'hFF00);
    add_reg(sfs_pkg::CFG_BURST, 16'h0000);
    add_reg(sfs_pkg::CFG_MAGAZINE, 16'h0001);
    add_reg(CFG_UNUSED, 16'h0005);
    add_tick(LV_RELEASED);
    add_tick(LV_MODE);
    add_tick(LV_RELEASED);
    add_tick(LV_SHOOT);
    add_tick(LV_SHOOT);
    add_tick(LV_REV);
    add_tick(LV_SHOOT);
    add_tick(LV_REV_MODE);
    add_tick(LV_SHOOT);
    add_tick(LV_REV);
    add_tick(LV_ALL);
    add_tick(LV_SHOOT);
    add_tick(LV_SHOOT);
    add_tick(LV_ALL);
    add_tick(LV_RELEASED);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].is_reg) begin
        if (!cfg_open) drain();
        write_reg(plan[i].reg_idx, plan[i].reg_data, sfs_pkg::CfgDatW);
        cfg_open = 1'b1;
      end else begin
        if (cfg_open) begin
          cfg_valid <= 1'b0;
          cfg_open = 1'b0;
        end
        send_tick(plan[i].lv, plan[i].fixed, plan[i].want);
      end
    end

    for (int ph = 0; ph < 4; ph++) begin
      if (ph == 1) begin
        src_idle = 87;
        dst_idle = 24;
      end else if (ph == 3) begin
        src_idle = 0;
        dst_idle = 0;
        // largest settings, then one shot with the longest pusher pulse
        program_regs(1023, 65535, 4095, 4095, 255, 15, 255);
        repeat (60) send_tick(next_levels(), 1'b0, '0);
        program_regs(0, 1, 40, 20, 255, 15, 255);
        first_shot = shots_fired;
        guard = 0;
        do begin
          send_tick(next_levels(), 1'b0, '0);
          guard++;
        end while (!(shots_fired > first_shot && shot_phase == PH_IDLE && feed_cool == 0 &&
                     push_cool == 0) && guard < 1500);
      end
      program_regs($urandom_range(0, 3), $urandom_range(1, 12), $urandom_range(0, 4),
                   $urandom_range(0, 3), $urandom_range(1, 4), $urandom_range(1, 15),
                   $urandom_range(0, 8));
      for (int k = 0; k < RAND_ITEMS; k++) begin
        if (k == RAND_ITEMS / 2 || $urandom_range(0, 149) == 0) drain();
        send_tick(next_levels(), 1'b0, '0);
      end
    end

    drain();
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("select_fire_sequencer_top verification clean");
    end else begin
      $display("select_fire_sequencer_top verification failed");
    end
    $finish;
  end

endmodule
